// ----- rtl/core/istfl_pkg.sv -----
`default_nettype none
package istfl_pkg;

   typedef enum logic [2:0] {
      OP_ALLOC   = 3'd0,
      OP_RELEASE = 3'd1,
      OP_INSERT  = 3'd2,
      OP_REMOVE  = 3'd3,
      OP_LOOKUP  = 3'd4
   } op_type;

   typedef enum logic [1:0] {
      ST_DONE      = 2'd0,
      ST_NO_FREE   = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

   typedef struct packed {
      logic [2:0]  op;
      logic [7:0]  slot;
      logic [30:0] ident;
   } req_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] slot_out;
      logic [8:0] in_use;
   } rsp_type;

   typedef enum logic [3:0] {
      S_INIT,
      S_IDLE,
      S_DISPATCH,
      S_ALLOC_RD,
      S_INS_WR,
      S_RM_IDENT,
      S_RM_HEAD,
      S_RM_WALK,
      S_LK_HEAD,
      S_LK_WALK,
      S_FINISH
   } state_type;

   typedef struct packed {
      logic init_step;
      logic load_req;
      logic do_alloc_rd;
      logic do_alloc;
      logic do_release;
      logic do_insert;
      logic rd_ident;
      logic rd_head;
      logic rm_step;
      logic lk_fetch;
      logic lk_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic       init_done;
      logic       slot_ok;
      logic       free_empty;
      logic       walk_end;
      logic       hit;
      logic [2:0] op;
   } sts_type;

endpackage
`default_nettype wire

// ----- rtl/core/id_slot_table_with_free_list_top.sv -----
// Release, unknown codes and an allocate with no free slot go from dispatch straight to finish;
// allocate passes S_ALLOC_RD, insert S_INS_WR; remove reads the slot's identifier and bucket head,
// then walks the chain; lookup fetches and compares each chain entry (at most NUM_SLOTS entries).
// Throughput: one command at a time; busy drops in the strobe cycle, so the next transfer can be
// accepted at the edge that ends it. The receiver cannot stall a result.
// Reset: a sweep over the larger of NUM_SLOTS and NUM_BUCKETS entries, with busy high.
`default_nettype none
module id_slot_table_with_free_list_top #(
   parameter int NUM_SLOTS   = 256,
   parameter int NUM_BUCKETS = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire istfl_pkg::req_type req_data,
   output logic                    rsp_strobe,
   output istfl_pkg::rsp_type      rsp_data
);
   import istfl_pkg::*;

   cmd_type cmd;
   sts_type sts;

   istfl_ctrl u_ctrl (
      .clock (clock), .reset (reset), .start (start), .busy (busy),
      .sts (sts), .cmd (cmd)
   );

   istfl_dp #(.NUM_SLOTS(NUM_SLOTS), .NUM_BUCKETS(NUM_BUCKETS)) u_dp (
      .clock (clock), .reset (reset), .req (req_data), .cmd (cmd), .sts (sts),
      .rsp_valid (rsp_strobe), .rsp (rsp_data)
   );

   a_strobe_after_finish: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_strobe) else $error("missing result strobe");
   a_busy_while_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(busy)) else $error("strobe without command");
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (32'(rsp_data.in_use) <= NUM_SLOTS)) else $error("count overflow");
endmodule
`default_nettype wire

// ----- rtl/core/istfl_ctrl.sv -----
`default_nettype none
module istfl_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   output logic                  busy,
   input  wire istfl_pkg::sts_type sts,
   output istfl_pkg::cmd_type    cmd
);
   import istfl_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_INIT;
      else       state_ff <= state_in;
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      unique case (state_ff)
         S_INIT: begin
            cmd.init_step = 1'b1;
            if (sts.init_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load_req = 1'b1;
               state_in = S_DISPATCH;
            end
         end
         S_DISPATCH: begin
            state_in = S_FINISH;
            case (sts.op)
               OP_ALLOC: begin
                  if (!sts.free_empty) begin
                     cmd.do_alloc_rd = 1'b1;
                     state_in = S_ALLOC_RD;
                  end
               end
               OP_RELEASE: cmd.do_release = sts.slot_ok;
               OP_INSERT: begin
                  if (sts.slot_ok) begin
                     cmd.rd_head = 1'b1;
                     state_in = S_INS_WR;
                  end
               end
               OP_REMOVE: begin
                  if (sts.slot_ok) begin
                     cmd.rd_ident = 1'b1;
                     state_in = S_RM_IDENT;
                  end
               end
               OP_LOOKUP: begin
                  cmd.rd_head = 1'b1;
                  state_in = S_LK_HEAD;
               end
               default: state_in = S_FINISH;
            endcase
         end
         S_ALLOC_RD: begin
            cmd.do_alloc = 1'b1;
            state_in = S_FINISH;
         end
         S_INS_WR: begin
            cmd.do_insert = 1'b1;
            state_in = S_FINISH;
         end
         S_RM_IDENT: begin
            cmd.rd_head = 1'b1;
            state_in = S_RM_HEAD;
         end
         S_RM_HEAD: state_in = S_RM_WALK;
         S_RM_WALK: begin
            cmd.rm_step = 1'b1;
            if (sts.walk_end || sts.hit) state_in = S_FINISH;
         end
         S_LK_HEAD: begin
            cmd.lk_fetch = 1'b1;
            state_in = S_LK_WALK;
         end
         S_LK_WALK: begin
            cmd.lk_step = 1'b1;
            if (sts.walk_end || sts.hit) state_in = S_FINISH;
            else state_in = S_LK_HEAD;
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_INIT;
      endcase
   end
endmodule
`default_nettype wire

// ----- rtl/core/istfl_dp.sv -----
`default_nettype none
module istfl_dp #(
   parameter int NUM_SLOTS   = 256,
   parameter int NUM_BUCKETS = 128
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire istfl_pkg::req_type req,
   input  wire istfl_pkg::cmd_type cmd,
   output istfl_pkg::sts_type      sts,
   output logic                    rsp_valid,
   output istfl_pkg::rsp_type      rsp
);
   import istfl_pkg::*;

   localparam int LW = $clog2(NUM_SLOTS + 1);
   localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
   localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
   localparam int CW = $clog2(NUM_SLOTS + 1);
   localparam int INIT_N = (NUM_SLOTS > NUM_BUCKETS) ? NUM_SLOTS : NUM_BUCKETS;
   localparam int IW = $clog2(INIT_N + 1);
   localparam logic [LW-1:0] NIL = LW'(NUM_SLOTS);

   logic [LW-1:0] free_next_mem [NUM_SLOTS];
   logic [LW-1:0] chain_mem     [NUM_SLOTS];
   logic [30:0]   ident_mem     [NUM_SLOTS];
   logic [LW-1:0] head_mem      [NUM_BUCKETS];

   req_type       req_ff;
   logic [LW-1:0] free_head_ff;
   logic [CW-1:0] used_ff;
   logic [IW-1:0] init_ff;
   logic [LW-1:0] cur_ff, prev_ff;
   logic [CW-1:0] steps_ff;
   logic [BW-1:0] bkt_ff;
   logic [LW-1:0] fn_rd_ff, head_rd_ff, chain_rd_ff, snext_ff;
   logic [30:0]   ident_rd_ff;
   logic [1:0]    status_ff;
   logic [7:0]    sout_ff;
   logic          rsp_valid_ff;
   logic          walk_first_ff;

   logic [LW-1:0] slot_ext;
   logic [BW-1:0] req_bkt, id_bkt;
   logic [LW-1:0] cur_now;
   logic          cur_end;

   assign slot_ext = LW'(req_ff.slot);
   assign req_bkt  = BW'(req_ff.ident % NUM_BUCKETS);
   assign id_bkt   = BW'(ident_rd_ff % NUM_BUCKETS);
   assign cur_now  = walk_first_ff ? head_rd_ff : chain_rd_ff;
   assign cur_end  = (cur_now >= NIL) || (steps_ff >= CW'(NUM_SLOTS));

   assign sts.init_done  = (init_ff == IW'(INIT_N));
   assign sts.slot_ok    = (32'(req_ff.slot) < NUM_SLOTS);
   assign sts.free_empty = (free_head_ff >= NIL);
   assign sts.walk_end   = cur_end;
   assign sts.hit        = !cur_end && (cmd.rm_step ? (cur_now == slot_ext)
                                                    : (ident_rd_ff == req_ff.ident));
   assign sts.op         = req_ff.op;

   always_ff @(posedge clock) begin
      if (reset) begin
         init_ff      <= '0;
         free_head_ff <= '0;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.finish;
         if (cmd.init_step && !sts.init_done) init_ff <= init_ff + 1'b1;
         if (cmd.do_alloc) begin
            free_head_ff <= fn_rd_ff;
            if (used_ff < CW'(NUM_SLOTS)) used_ff <= used_ff + 1'b1;
         end
         if (cmd.do_release) begin
            free_head_ff <= slot_ext;
            if (used_ff != '0) used_ff <= used_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_step && !sts.init_done) begin
         if (32'(init_ff) < NUM_SLOTS)
            free_next_mem[init_ff[SW-1:0]] <= LW'(init_ff) + 1'b1;
         if (32'(init_ff) < NUM_BUCKETS) head_mem[BW'(init_ff)] <= NIL;
      end
      if (cmd.load_req) begin
         req_ff    <= req;
         status_ff <= ST_DONE;
         sout_ff   <= '0;
      end
      fn_rd_ff <= free_next_mem[free_head_ff[SW-1:0]];
      if (cmd.do_alloc_rd) sout_ff <= 8'(free_head_ff);
      if (sts.op == OP_ALLOC && sts.free_empty && !cmd.finish && !cmd.load_req
          && !cmd.init_step)
         status_ff <= ST_NO_FREE;
      if (cmd.do_release) free_next_mem[slot_ext[SW-1:0]] <= free_head_ff;
      if (cmd.do_insert) begin
         ident_mem[slot_ext[SW-1:0]] <= req_ff.ident;
         chain_mem[slot_ext[SW-1:0]] <= head_rd_ff;
         head_mem[req_bkt]           <= slot_ext;
      end
      if (cmd.rd_ident) begin
         ident_rd_ff <= ident_mem[slot_ext[SW-1:0]];
         snext_ff    <= chain_mem[slot_ext[SW-1:0]];
      end
      if (cmd.rd_head) begin
         bkt_ff        <= (req_ff.op == OP_REMOVE) ? id_bkt : req_bkt;
         head_rd_ff    <= head_mem[(req_ff.op == OP_REMOVE) ? id_bkt : req_bkt];
         walk_first_ff <= 1'b1;
         steps_ff      <= '0;
         prev_ff       <= NIL;
      end
      if (cmd.rm_step) begin
         if (sts.hit) begin
            if (prev_ff == NIL) head_mem[bkt_ff] <= snext_ff;
            else chain_mem[prev_ff[SW-1:0]] <= snext_ff;
         end else begin
            prev_ff       <= cur_now;
            chain_rd_ff   <= chain_mem[cur_now[SW-1:0]];
            walk_first_ff <= 1'b0;
            steps_ff      <= steps_ff + 1'b1;
         end
      end
      if (cmd.lk_fetch) ident_rd_ff <= ident_mem[cur_now[SW-1:0]];
      if (cmd.lk_step) begin
         if (sts.hit) sout_ff <= 8'(cur_now);
         else if (cur_end) status_ff <= ST_NOT_FOUND;
      end
      if (cmd.lk_step && !sts.hit && !cur_end) begin
         chain_rd_ff   <= chain_mem[cur_now[SW-1:0]];
         walk_first_ff <= 1'b0;
         steps_ff      <= steps_ff + 1'b1;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp.status    = status_ff;
   assign rsp.slot_out  = sout_ff;
   assign rsp.in_use    = 9'(used_ff);
endmodule
`default_nettype wire
